@@ rtl/core/lct_pkg.sv @@
`default_nettype none

package lct_pkg;

  // window size limit and count width
  localparam int MAX_SAMPLES = 4096;
  localparam int CNT_W       = 13;

  // luma weights in thousandths
  localparam int LUMA_R = 299;
  localparam int LUMA_G = 587;
  localparam int LUMA_B = 114;

  // luma variance floor per sample (1.0 in thousandths squared)
  localparam int LUMA_VAR_MIN = 1000000;
  // luma error scale (thousandths)
  localparam int ERR_SCALE    = 1000;

  // term weights in percent
  localparam int W_LUMA   = 60;
  localparam int W_CHROMA = 25;
  localparam int W_COLOR  = 15;

  localparam int Q16_ONE = 65536;

  // floor(x / 100) as (x * RECIP_M) >> RECIP_SH, exact for x < 2^23
  localparam int RECIP_SH = 30;
  localparam int RECIP_M  = ((1 << RECIP_SH) + 99) / 100;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MIN_SAMPLES = 2'd0,
    CFG_ALPHA_THR   = 2'd1,
    CFG_ERR_DIV     = 2'd2
  } cfg_idx_e;

  // finished window sums, handed from front to back
  typedef struct packed {
    logic        [CNT_W-1:0] n;
    logic        [29:0]      tls;
    logic        [29:0]      sls;
    logic        [47:0]      tlq;
    logic        [47:0]      slq;
    logic        [47:0]      lx;
    logic signed [20:0]      tcs;
    logic signed [20:0]      scs;
    logic        [27:0]      tcq;
    logic        [27:0]      scq;
    logic signed [28:0]      cx;
    logic        [29:0]      err;
  } lct_sums_t;

endpackage

`default_nettype wire

@@ rtl/core/lct_front.sv @@
`default_nettype none

module lct_front
  import lct_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] template_red_i,
  input  wire logic [7:0] template_green_i,
  input  wire logic [7:0] template_blue_i,
  input  wire logic [7:0] template_alpha_i,
  input  wire logic [7:0] screen_red_i,
  input  wire logic [7:0] screen_green_i,
  input  wire logic [7:0] screen_blue_i,
  input  wire logic       sample_inside_i,
  input  wire logic       last_sample_i,
  input  wire logic [7:0] alpha_threshold_i,
  output lct_sums_t       snap_o,
  output logic            snap_valid_o,
  input  wire logic       snap_pop_i
);

  // stage a: per-pixel luma and chroma
  logic              a_valid_q, a_keep_q, a_last_q;
  logic [17:0]       a_lt_q, a_ls_q;
  logic signed [8:0] a_ct_q, a_cs_q;

  logic [17:0]       lt_d, ls_d;
  logic signed [8:0] ct_d, cs_d;
  logic              accept, b_go, fire, take;

  lct_sums_t acc_q, acc_d, snap_q;
  logic      snap_valid_q;

  logic [35:0]        lt2, ls2, lx2;
  logic signed [17:0] ct2, cs2, cx2;
  logic [17:0]        err;

  assign lt_d = 18'(18'(LUMA_R) * 18'(template_red_i) + 18'(LUMA_G) * 18'(template_green_i)
              + 18'(LUMA_B) * 18'(template_blue_i));
  assign ls_d = 18'(18'(LUMA_R) * 18'(screen_red_i) + 18'(LUMA_G) * 18'(screen_green_i)
              + 18'(LUMA_B) * 18'(screen_blue_i));
  assign ct_d = $signed({1'b0, template_red_i}) - $signed({1'b0, template_blue_i});
  assign cs_d = $signed({1'b0, screen_red_i}) - $signed({1'b0, screen_blue_i});

  // a closing word waits while the previous window is still in the queue
  assign b_go       = !a_last_q || !snap_valid_q;
  assign fire       = a_valid_q && b_go;
  assign in_stall_o = a_valid_q && !b_go;
  assign accept     = in_valid_i && !in_stall_o;
  assign take       = a_keep_q && (acc_q.n < CNT_W'(MAX_SAMPLES));

  assign lt2 = 36'(a_lt_q) * 36'(a_lt_q);
  assign ls2 = 36'(a_ls_q) * 36'(a_ls_q);
  assign lx2 = 36'(a_lt_q) * 36'(a_ls_q);
  assign ct2 = 18'(a_ct_q) * 18'(a_ct_q);
  assign cs2 = 18'(a_cs_q) * 18'(a_cs_q);
  assign cx2 = 18'(a_ct_q) * 18'(a_cs_q);
  assign err = (a_lt_q >= a_ls_q) ? (a_lt_q - a_ls_q) : (a_ls_q - a_lt_q);

  always_comb begin
    acc_d = acc_q;
    if (take) begin
      acc_d.n   = acc_q.n + CNT_W'(1);
      acc_d.tls = acc_q.tls + 30'(a_lt_q);
      acc_d.sls = acc_q.sls + 30'(a_ls_q);
      acc_d.tlq = acc_q.tlq + 48'(lt2);
      acc_d.slq = acc_q.slq + 48'(ls2);
      acc_d.lx  = acc_q.lx + 48'(lx2);
      acc_d.tcs = acc_q.tcs + 21'(a_ct_q);
      acc_d.scs = acc_q.scs + 21'(a_cs_q);
      acc_d.tcq = acc_q.tcq + 28'(ct2);
      acc_d.scq = acc_q.scq + 28'(cs2);
      acc_d.cx  = acc_q.cx + 29'(cx2);
      acc_d.err = acc_q.err + 30'(err);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q    <= 1'b0;
      a_keep_q     <= 1'b0;
      a_last_q     <= 1'b0;
      a_lt_q       <= '0;
      a_ls_q       <= '0;
      a_ct_q       <= '0;
      a_cs_q       <= '0;
      acc_q        <= '0;
      snap_q       <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
        a_keep_q  <= sample_inside_i && (template_alpha_i >= alpha_threshold_i);
        a_last_q  <= last_sample_i;
        a_lt_q    <= lt_d;
        a_ls_q    <= ls_d;
        a_ct_q    <= ct_d;
        a_cs_q    <= cs_d;
      end else if (b_go) begin
        a_valid_q <= 1'b0;
      end
      if (snap_pop_i) begin
        snap_valid_q <= 1'b0;
      end
      if (fire) begin
        if (a_last_q) begin
          snap_q       <= acc_d;
          snap_valid_q <= 1'b1;
          acc_q        <= '0;
        end else begin
          acc_q <= acc_d;
        end
      end
    end
  end

  assign snap_o       = snap_q;
  assign snap_valid_o = snap_valid_q;

endmodule

`default_nettype wire

@@ rtl/core/lct_isqrt.sv @@
`default_nettype none

module lct_isqrt
  import lct_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] value_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] val_q;
  logic [35:0] rem_q, rem_n, trial;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;

  // one result bit per cycle
  assign rem_n = {rem_q[33:0], val_q[63:62]};
  assign trial = {2'b00, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        val_q  <= value_i;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        val_q <= {val_q[61:0], 2'b00};
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[30:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[30:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ rtl/core/lct_back.sv @@
`default_nettype none

module lct_back
  import lct_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire lct_sums_t        snap_i,
  input  wire logic             snap_valid_i,
  output logic                  snap_pop_o,
  input  wire logic [CNT_W-1:0] min_samples_i,
  input  wire logic [7:0]       error_divisor_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [16:0]           score_o,
  output logic [CNT_W-1:0]      kept_count_o,
  output logic                  too_few_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_SUB, ST_CHK, ST_SQA, ST_SQB, ST_DMUL,
    ST_DIVI, ST_DIV, ST_STORE, ST_SUM, ST_SCALE, ST_OUT
  } state_e;

  typedef enum logic [1:0] {PH_LUMA, PH_CHROMA, PH_COLOR} phase_e;

  state_e state_q;
  phase_e ph_q;

  logic [2:0]         idx_q;
  logic signed [63:0] pn_q, ps_q;
  logic signed [63:0] v_q [6];
  logic [32:0]        thr_q;
  logic [29:0]        den_q;
  logic [63:0]        cov_q, d_q, r_q;
  logic [31:0]        sa_q, sb_q;
  logic [15:0]        q_q;
  logic [3:0]         cnt_q;
  logic [16:0]        res_q, lt_q, ct_q, kt_q;
  logic [22:0]        sum_q;
  logic [16:0]        score_q;
  logic               few_q;
  logic               out_valid_q;
  logic [16:0]        out_score_q;
  logic [CNT_W-1:0]   out_kept_q;
  logic               out_few_q;

  // shared multipliers
  logic signed [48:0] mx;
  logic signed [30:0] my, mz;
  logic signed [13:0] nn;
  logic signed [63:0] pn_d, ps_d;

  logic signed [63:0] va, vb, cv, thr;
  logic               ncc_zero, sq_start, sq_done;
  logic [63:0]        sq_val;
  logic [31:0]        sq_root;
  logic [64:0]        r2;
  logic               ge;
  logic [46:0]        scaled;
  logic               out_free;

  assign nn = $signed({1'b0, snap_i.n});

  always_comb begin
    mx = '0;
    my = '0;
    mz = '0;
    case (idx_q)
      3'd0: begin
        mx = 49'(snap_i.tlq);
        my = 31'(snap_i.tls);
        mz = 31'(snap_i.tls);
      end
      3'd1: begin
        mx = 49'(snap_i.slq);
        my = 31'(snap_i.sls);
        mz = 31'(snap_i.sls);
      end
      3'd2: begin
        mx = 49'(snap_i.lx);
        my = 31'(snap_i.tls);
        mz = 31'(snap_i.sls);
      end
      3'd3: begin
        mx = 49'(snap_i.tcq);
        my = 31'(snap_i.tcs);
        mz = 31'(snap_i.tcs);
      end
      3'd4: begin
        mx = 49'(snap_i.scq);
        my = 31'(snap_i.scs);
        mz = 31'(snap_i.scs);
      end
      3'd5: begin
        mx = 49'(snap_i.cx);
        my = 31'(snap_i.tcs);
        mz = 31'(snap_i.scs);
      end
      default: begin
        mx = '0;
      end
    endcase
  end

  assign pn_d = nn * mx;
  assign ps_d = my * mz;

  // operands of the correlation in progress
  always_comb begin
    if (ph_q == PH_LUMA) begin
      va  = v_q[0];
      vb  = v_q[1];
      cv  = v_q[2];
      thr = $signed({31'b0, thr_q});
    end else begin
      va  = v_q[3];
      vb  = v_q[4];
      cv  = v_q[5];
      thr = $signed(64'(snap_i.n));
    end
  end

  assign ncc_zero = (va <= thr) || (vb <= thr) || (cv <= 64'sd0);
  assign sq_start = (state_q == ST_CHK && ph_q != PH_COLOR && !ncc_zero)
                 || (state_q == ST_SQA && sq_done);
  assign sq_val   = (state_q == ST_SQA) ? 64'(vb) : 64'(va);

  lct_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_val),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // restoring divide, one quotient bit per cycle
  assign r2 = {r_q, 1'b0};
  assign ge = r2 >= {1'b0, d_q};

  assign scaled   = 47'(sum_q) * 47'(RECIP_M);
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_LUMA;
      idx_q       <= '0;
      pn_q        <= '0;
      ps_q        <= '0;
      for (int i = 0; i < 6; i++) v_q[i] <= '0;
      thr_q       <= '0;
      den_q       <= '0;
      cov_q       <= '0;
      d_q         <= '0;
      r_q         <= '0;
      sa_q        <= '0;
      sb_q        <= '0;
      q_q         <= '0;
      cnt_q       <= '0;
      res_q       <= '0;
      lt_q        <= '0;
      ct_q        <= '0;
      kt_q        <= '0;
      sum_q       <= '0;
      score_q     <= '0;
      few_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_score_q <= '0;
      out_kept_q  <= '0;
      out_few_q   <= 1'b0;
      snap_pop_o  <= 1'b0;
    end else begin
      snap_pop_o <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (snap_valid_i && !snap_pop_o) begin
            few_q   <= (snap_i.n == '0) || (snap_i.n < min_samples_i);
            score_q <= '0;
            idx_q   <= '0;
            ph_q    <= PH_LUMA;
            thr_q   <= 33'(33'(snap_i.n) * 33'(LUMA_VAR_MIN));
            den_q   <= 30'(30'(snap_i.n) * 30'(ERR_SCALE) * 30'(error_divisor_i));
            if ((snap_i.n == '0) || (snap_i.n < min_samples_i)) begin
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          pn_q    <= pn_d;
          ps_q    <= ps_d;
          state_q <= ST_SUB;
        end
        ST_SUB: begin
          v_q[idx_q] <= pn_q - ps_q;
          if (idx_q == 3'd5) begin
            state_q <= ST_CHK;
          end else begin
            idx_q   <= idx_q + 3'd1;
            state_q <= ST_MUL;
          end
        end
        ST_CHK: begin
          if (ph_q == PH_COLOR) begin
            cov_q   <= 64'(snap_i.err);
            d_q     <= 64'(den_q);
            state_q <= ST_DIVI;
          end else if (ncc_zero) begin
            res_q   <= '0;
            state_q <= ST_STORE;
          end else begin
            cov_q   <= 64'(cv);
            state_q <= ST_SQA;
          end
        end
        ST_SQA: begin
          if (sq_done) begin
            sa_q    <= sq_root;
            state_q <= ST_SQB;
          end
        end
        ST_SQB: begin
          if (sq_done) begin
            sb_q    <= sq_root;
            state_q <= ST_DMUL;
          end
        end
        ST_DMUL: begin
          d_q     <= 64'(sa_q) * 64'(sb_q);
          state_q <= ST_DIVI;
        end
        ST_DIVI: begin
          if (d_q == '0) begin
            // no divisor: the color term reads as zero, a correlation as zero
            res_q   <= (ph_q == PH_COLOR) ? 17'(Q16_ONE) : '0;
            state_q <= ST_STORE;
          end else if (cov_q >= d_q) begin
            res_q   <= 17'(Q16_ONE);
            state_q <= ST_STORE;
          end else begin
            r_q     <= cov_q;
            q_q     <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          r_q   <= ge ? 64'(r2 - {1'b0, d_q}) : r2[63:0];
          q_q   <= {q_q[14:0], ge};
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == 4'd15) begin
            res_q   <= {1'b0, q_q[14:0], ge};
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          case (ph_q)
            PH_LUMA: begin
              lt_q    <= res_q;
              ph_q    <= PH_CHROMA;
              state_q <= ST_CHK;
            end
            PH_CHROMA: begin
              ct_q    <= res_q;
              ph_q    <= PH_COLOR;
              state_q <= ST_CHK;
            end
            default: begin
              kt_q    <= 17'(Q16_ONE) - res_q;
              state_q <= ST_SUM;
            end
          endcase
        end
        ST_SUM: begin
          sum_q   <= 23'(23'(W_LUMA) * 23'(lt_q) + 23'(W_CHROMA) * 23'(ct_q)
                   + 23'(W_COLOR) * 23'(kt_q));
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          score_q <= scaled[RECIP_SH+16:RECIP_SH];
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_score_q <= score_q;
            out_kept_q  <= snap_i.n;
            out_few_q   <= few_q;
            snap_pop_o  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign score_o      = out_score_q;
  assign kept_count_o = out_kept_q;
  assign too_few_o    = out_few_q;

endmodule

`default_nettype wire

@@ rtl/core/luma_chroma_template_score.sv @@
`default_nettype none

// template match scorer: luma and chroma correlation plus mean luma error
// input channel: one word per pixel pair (template rgba, screen rgb, inside
//   flag, last flag), handshake in_valid_i / in_stall_o
// output channel: one word per window (score in q16, kept count, too-few
//   flag), handshake out_valid_o / out_stall_i, raised after the word
//   carrying last_sample
// config port: cfg_we_i writes cfg_data_i into register cfg_index_i
//   (0 min samples, 1 alpha threshold, 2 error divisor); write only when idle
// throughput: one pixel word per cycle inside a window; the front end sums
//   while the back end scores the previous window from a one-deep queue
// sequencing: once the last word is taken, the serial back end runs its multiply
//   steps, four square roots and three divides before the result word rises;
//   a window with too few samples goes straight to the output, and a flat
//   window skips its correlation roots and divides
// a last word stalls only while the queue still holds an unscored window
// reset: all sums, the queue and the output register clear, config returns
//   to 24 / 96 / 160
// a stalled output holds its word; the back end waits for it to drain

module luma_chroma_template_score
  import lct_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CNT_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [7:0]       template_red_i,
  input  wire logic [7:0]       template_green_i,
  input  wire logic [7:0]       template_blue_i,
  input  wire logic [7:0]       template_alpha_i,
  input  wire logic [7:0]       screen_red_i,
  input  wire logic [7:0]       screen_green_i,
  input  wire logic [7:0]       screen_blue_i,
  input  wire logic             sample_inside_i,
  input  wire logic             last_sample_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [16:0]           score_o,
  output logic [CNT_W-1:0]      kept_count_o,
  output logic                  too_few_o
);

  // configuration registers
  logic [CNT_W-1:0] min_samples_q;
  logic [7:0]       alpha_thr_q;
  logic [7:0]       err_div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_samples_q <= CNT_W'(24);
      alpha_thr_q   <= 8'd96;
      err_div_q     <= 8'd160;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_SAMPLES: min_samples_q <= cfg_data_i;
        CFG_ALPHA_THR:   alpha_thr_q   <= cfg_data_i[7:0];
        CFG_ERR_DIV:     err_div_q     <= cfg_data_i[7:0];
        default: begin
          // unused index, ignored
        end
      endcase
    end
  end

  // finished window sums in flight between the two halves
  lct_sums_t snap;
  logic      snap_valid, snap_pop;

  lct_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .template_red_i    (template_red_i),
    .template_green_i  (template_green_i),
    .template_blue_i   (template_blue_i),
    .template_alpha_i  (template_alpha_i),
    .screen_red_i      (screen_red_i),
    .screen_green_i    (screen_green_i),
    .screen_blue_i     (screen_blue_i),
    .sample_inside_i   (sample_inside_i),
    .last_sample_i     (last_sample_i),
    .alpha_threshold_i (alpha_thr_q),
    .snap_o            (snap),
    .snap_valid_o      (snap_valid),
    .snap_pop_i        (snap_pop)
  );

  lct_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .snap_i          (snap),
    .snap_valid_i    (snap_valid),
    .snap_pop_o      (snap_pop),
    .min_samples_i   (min_samples_q),
    .error_divisor_i (err_div_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .score_o         (score_o),
    .kept_count_o    (kept_count_o),
    .too_few_o       (too_few_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/lct_checker.sv @@
`default_nettype none

module lct_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [16:0] score_o,
  input wire logic [12:0] kept_count_o,
  input wire logic        too_few_o
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(score_o)
      && $stable(kept_count_o) && $stable(too_few_o))
    else $error("stalled result changed");

  // too few samples always scores zero
  a_few_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_few_o |-> score_o == 17'd0)
    else $error("too_few with nonzero score");

  // score never exceeds 1.0
  a_score_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> score_o <= 17'd65536)
    else $error("score above one");

  // kept count saturates at the window limit, and zero is always too few
  a_kept_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kept_count_o <= 13'd4096 && (kept_count_o != 13'd0 || too_few_o))
    else $error("kept count out of range");

endmodule

bind luma_chroma_template_score lct_checker u_lct_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .score_o      (score_o),
  .kept_count_o (kept_count_o),
  .too_few_o    (too_few_o)
);

`default_nettype wire

@@ dv/lct_checker.sv @@
`default_nettype none

module lct_scoreboard
  import lct_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_index_i,
  input  wire logic [CNT_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  input  wire logic             in_stall_i,
  input  wire logic [7:0]       template_red_i,
  input  wire logic [7:0]       template_green_i,
  input  wire logic [7:0]       template_blue_i,
  input  wire logic [7:0]       template_alpha_i,
  input  wire logic [7:0]       screen_red_i,
  input  wire logic [7:0]       screen_green_i,
  input  wire logic [7:0]       screen_blue_i,
  input  wire logic             sample_inside_i,
  input  wire logic             last_sample_i,
  input  wire logic             out_valid_i,
  input  wire logic             out_stall_i,
  input  wire logic [16:0]      score_i,
  input  wire logic [CNT_W-1:0] kept_count_i,
  input  wire logic             too_few_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct {
    logic [16:0]      score;
    logic [CNT_W-1:0] kept;
    logic             few;
  } window_score_t;

  window_score_t expected_scores[$];

  logic [CNT_W-1:0] min_kept;
  logic [7:0]       alpha_min;
  logic [7:0]       err_div;

  longint unsigned kept_n;
  longint unsigned t_luma_sum, s_luma_sum, t_luma_sq, s_luma_sq, luma_xy, err_sum;
  longint          t_chroma_sum, s_chroma_sum, chroma_xy;
  longint unsigned t_chroma_sq, s_chroma_sq;

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    fail_count_o++;
  endtask

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned step;
    root = 0;
    step = 64'd1 << 62;
    while (step > v) step >>= 2;
    while (step != 0) begin
      if (v >= root + step) begin
        v    = v - (root + step);
        root = (root >> 1) + step;
      end else begin
        root >>= 1;
      end
      step >>= 2;
    end
    return root;
  endfunction

  // q16 correlation, clamped at one
  function automatic longint unsigned corr_q16(input longint unsigned cov,
                                               input longint unsigned va,
                                               input longint unsigned vb);
    longint unsigned den;
    longint unsigned rem;
    longint unsigned q;
    den = floor_sqrt(va) * floor_sqrt(vb);
    rem = cov;
    q   = 0;
    if (den == 0 || cov == 0) return 0;
    if (cov >= den) return 65536;
    for (int i = 0; i < 16; i++) begin
      q <<= 1;
      if (rem >= den - rem) begin
        rem = rem - (den - rem);
        q   = q | 1;
      end else begin
        rem <<= 1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned luma_corr();
    longint unsigned vt, vs, nt, ns, np, ss, floor_v;
    nt      = kept_n * t_luma_sq;
    ns      = kept_n * s_luma_sq;
    vt      = t_luma_sum * t_luma_sum;
    vs      = s_luma_sum * s_luma_sum;
    np      = kept_n * luma_xy;
    ss      = t_luma_sum * s_luma_sum;
    floor_v = kept_n * LUMA_VAR_MIN;
    if (nt <= vt || nt - vt <= floor_v) return 0;
    if (ns <= vs || ns - vs <= floor_v) return 0;
    if (np <= ss) return 0;
    return corr_q16(np - ss, nt - vt, ns - vs);
  endfunction

  function automatic longint unsigned chroma_corr();
    longint n, va, vb, cv;
    n  = longint'(kept_n);
    va = n * longint'(t_chroma_sq) - t_chroma_sum * t_chroma_sum;
    vb = n * longint'(s_chroma_sq) - s_chroma_sum * s_chroma_sum;
    cv = n * chroma_xy - t_chroma_sum * s_chroma_sum;
    if (va <= n || vb <= n || cv <= 0) return 0;
    return corr_q16(cv, va, vb);
  endfunction

  function automatic longint unsigned color_match();
    longint unsigned den, ratio;
    den = kept_n * ERR_SCALE * err_div;
    if (den == 0) return 0;
    ratio = (err_sum << 16) / den;
    if (ratio >= 65536) return 0;
    return 65536 - ratio;
  endfunction

  task automatic clear_sums();
    kept_n = 0;
    t_luma_sum = 0; s_luma_sum = 0; t_luma_sq = 0; s_luma_sq = 0; luma_xy = 0;
    t_chroma_sum = 0; s_chroma_sum = 0; t_chroma_sq = 0; s_chroma_sq = 0;
    chroma_xy = 0; err_sum = 0;
  endtask

  task automatic absorb_pair();
    longint unsigned lt, ls;
    longint          ct, cs;
    window_score_t   w;
    if (sample_inside_i && template_alpha_i >= alpha_min && kept_n < MAX_SAMPLES) begin
      lt = LUMA_R * template_red_i + LUMA_G * template_green_i + LUMA_B * template_blue_i;
      ls = LUMA_R * screen_red_i + LUMA_G * screen_green_i + LUMA_B * screen_blue_i;
      ct = longint'(template_red_i) - longint'(template_blue_i);
      cs = longint'(screen_red_i) - longint'(screen_blue_i);
      t_luma_sum += lt;  s_luma_sum += ls;
      t_luma_sq  += lt * lt;  s_luma_sq += ls * ls;  luma_xy += lt * ls;
      t_chroma_sum += ct;  s_chroma_sum += cs;
      t_chroma_sq  += ct * ct;  s_chroma_sq += cs * cs;  chroma_xy += ct * cs;
      err_sum += (lt >= ls) ? lt - ls : ls - lt;
      kept_n++;
    end
    if (last_sample_i) begin
      w.kept  = kept_n[CNT_W-1:0];
      w.few   = (kept_n == 0) || (kept_n < min_kept);
      w.score = w.few ? '0 : 17'((W_LUMA * luma_corr() + W_CHROMA * chroma_corr()
                                  + W_COLOR * color_match()) / 100);
      expected_scores.insert(expected_scores.size(), w);
      clear_sums();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_score_t w;
    if (!rst_ni) begin
      min_kept  = 24;
      alpha_min = 96;
      err_div   = 160;
      clear_sums();
      expected_scores.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MIN_SAMPLES: min_kept  = cfg_data_i;
          CFG_ALPHA_THR:   alpha_min = cfg_data_i[7:0];
          CFG_ERR_DIV:     err_div   = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_pair();
      if (out_valid_i && !out_stall_i) begin
        if (expected_scores.size() == 0) begin
          report("unexpected word, score", score_i, 0);
        end else begin
          w = expected_scores.pop_front();
          if (score_i !== w.score) report("score", score_i, w.score);
          if (kept_count_i !== w.kept) report("kept_count", kept_count_i, w.kept);
          if (too_few_i !== w.few) report("too_few", too_few_i, w.few);
        end
      end
    end
    pending_o = expected_scores.size();
  end

endmodule

`default_nettype wire

@@ dv/luma_chroma_template_score_tb.sv @@
`default_nettype none

module luma_chroma_template_score_tb;
  import lct_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 400;
  localparam int HOLD_CYCLES = 900;

  typedef struct {
    logic [7:0] tr, tg, tb, ta, sr, sg, sb;
    logic       in_window, last;
  } pixel_pair_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       t_red = '0, t_green = '0, t_blue = '0, t_alpha = '0;
  logic [7:0]       s_red = '0, s_green = '0, s_blue = '0;
  logic             in_window = 1'b0, last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [16:0]      score;
  logic [CNT_W-1:0] kept_count;
  logic             too_few;
  int               fail_count, pending;

  // stimulus controls
  logic no_gaps = 1'b0;     // sender offers a word every cycle
  logic hold_go = 1'b0;     // asks the receiver for its long hold-off
  int   pairs_sent = 0;
  int   windows_sent = 0;
  int   cycle_count = 0;

  luma_chroma_template_score dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .template_red_i(t_red), .template_green_i(t_green),
    .template_blue_i(t_blue), .template_alpha_i(t_alpha),
    .screen_red_i(s_red), .screen_green_i(s_green), .screen_blue_i(s_blue),
    .sample_inside_i(in_window), .last_sample_i(last),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .score_o(score), .kept_count_o(kept_count), .too_few_o(too_few)
  );

  lct_scoreboard u_scoreboard (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .template_red_i(t_red), .template_green_i(t_green),
    .template_blue_i(t_blue), .template_alpha_i(t_alpha),
    .screen_red_i(s_red), .screen_green_i(s_green), .screen_blue_i(s_blue),
    .sample_inside_i(in_window), .last_sample_i(last),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .score_i(score), .kept_count_i(kept_count), .too_few_i(too_few),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // 20 unit clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off on request, then a quiet stretch
  always @(posedge clk_i) begin
    int hold_count;
    if (hold_go && hold_count < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_count++;
    end else if (hold_count >= HOLD_CYCLES && hold_count < HOLD_CYCLES + 2000) begin
      out_stall <= 1'b0;     // no stalls right after the hold
      hold_count++;
    end else begin
      out_stall <= ($urandom_range(99) < 12);
    end
  end

  // offer one word and wait for it to be taken; stall is sampled mid-cycle
  task automatic send_pair(input pixel_pair_t p);
    logic stalled;
    while (!no_gaps && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    t_red <= p.tr;  t_green <= p.tg;  t_blue <= p.tb;  t_alpha <= p.ta;
    s_red <= p.sr;  s_green <= p.sg;  s_blue <= p.sb;
    in_window <= p.in_window;
    last <= p.last;
    do begin
      @(negedge clk_i);
      stalled = in_stall;
      @(posedge clk_i);
    end while (stalled);
    pairs_sent++;
    if (p.last) windows_sent++;
  endtask

  // kinds of window content: screen follows, ignores or mirrors the template
  function automatic pixel_pair_t random_pair(input int kind, input int keep_pct);
    pixel_pair_t p;
    int noise;
    p.tr = 8'($urandom);  p.tg = 8'($urandom);  p.tb = 8'($urandom);
    p.ta = ($urandom_range(99) < keep_pct) ? 8'd255 : 8'($urandom);
    p.in_window = ($urandom_range(99) < keep_pct);
    p.last = 1'b0;
    noise = $urandom_range(40) - 20;
    case (kind)
      0: begin
        p.sr = 8'(int'(p.tr) + noise < 0 ? 0 : (int'(p.tr) + noise > 255 ? 255 : p.tr + noise));
        p.sg = p.tg;
        p.sb = 8'(int'(p.tb) - noise < 0 ? 0 : (int'(p.tb) - noise > 255 ? 255 : p.tb - noise));
      end
      1: begin
        p.sr = 8'($urandom);  p.sg = 8'($urandom);  p.sb = 8'($urandom);
      end
      default: begin
        p.sr = ~p.tr;  p.sg = ~p.tg;  p.sb = ~p.tb;
      end
    endcase
    return p;
  endfunction

  task automatic send_window(input int len, input int kind, input int keep_pct);
    pixel_pair_t p;
    for (int i = 0; i < len; i++) begin
      p = random_pair(kind, keep_pct);
      p.last = (i == len - 1);
      send_pair(p);
    end
    in_valid <= 1'b0;
  endtask

  // config only once every score is out and the back end has gone quiet
  task automatic write_reg(input cfg_idx_e idx, input int value);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CNT_W'(value);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int min_kept, input int alpha_min, input int err_div);
    write_reg(CFG_MIN_SAMPLES, min_kept);
    write_reg(CFG_ALPHA_THR, alpha_min);
    write_reg(CFG_ERR_DIV, err_div);
  endtask

  initial begin
    pixel_pair_t p;
    int kind;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset config: black and white kept, alpha one under and at the
    // threshold, a pair outside that closes a too-few window, then an empty one
    p = '{tr: 0, tg: 0, tb: 0, ta: 255, sr: 0, sg: 0, sb: 0, in_window: 1, last: 0};
    send_pair(p);
    p = '{tr: 255, tg: 255, tb: 255, ta: 255, sr: 255, sg: 255, sb: 255,
          in_window: 1, last: 0};
    send_pair(p);
    p = '{tr: 255, tg: 0, tb: 0, ta: 95, sr: 0, sg: 0, sb: 255, in_window: 1, last: 0};
    send_pair(p);
    p = '{tr: 0, tg: 0, tb: 255, ta: 96, sr: 255, sg: 0, sb: 0, in_window: 1, last: 0};
    send_pair(p);
    p = '{tr: 9, tg: 9, tb: 9, ta: 255, sr: 9, sg: 9, sb: 9, in_window: 0, last: 1};
    send_pair(p);
    p = '{tr: 1, tg: 2, tb: 3, ta: 0, sr: 4, sg: 5, sb: 6, in_window: 0, last: 1};
    send_pair(p);
    // flat window: variance under the floor, full color match
    for (int i = 0; i < 25; i++) begin
      p = '{tr: 50, tg: 60, tb: 70, ta: 200, sr: 50, sg: 60, sb: 70,
            in_window: 1, last: (i == 24)};
      send_pair(p);
    end
    in_valid <= 1'b0;

    // loosest settings
    set_config(1, 0, 1);
    for (int w = 0; w < 14; w++) send_window($urandom_range(1, 30), w % 3, 90);

    // strictest settings, every window too few
    set_config(MAX_SAMPLES, 255, 255);
    send_window(40, 0, 100);
    send_window(10, 1, 80);

    // zero minimum and zero divisor
    set_config(0, $urandom_range(255), 0);
    for (int w = 0; w < 8; w++) send_window($urandom_range(1, 30), w % 3, 85);

    // random settings, long receiver hold with the sender running flat out
    set_config($urandom_range(2, 40), $urandom_range(0, 200), $urandom_range(1, 255));
    hold_go <= 1'b1;
    no_gaps <= 1'b1;
    for (int w = 0; w < 10; w++) send_window($urandom_range(4, 30), w % 3, 90);
    no_gaps <= 1'b0;
    while (pairs_sent < 950 || windows_sent < 50) begin
      kind = $urandom_range(9) < 8 ? $urandom_range(2) : 1;
      // a few noisy windows with most pairs dropped
      send_window($urandom_range(1, 40), kind, ($urandom_range(9) == 0) ? 30 : 90);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
